// ===== src/i2cms_pkg.sv =====
package i2cms_pkg;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam int unsigned LEN_START = 3;
    localparam int unsigned LEN_STOP  = 3;
    localparam int unsigned LEN_WRITE = 27;
    localparam int unsigned LEN_READ  = 20;

    localparam logic [7:0] MSB_MASK = 8'h80;

    // sequence length per command code
    function automatic logic [4:0] seq_length(input logic [2:0] kind);
        logic [4:0] len;
        unique case (kind)
            OP_START: len = 5'(LEN_START);
            OP_STOP:  len = 5'(LEN_STOP);
            OP_WRITE: len = 5'(LEN_WRITE);
            OP_READ:  len = 5'(LEN_READ);
            default:  len = 5'd0;
        endcase
        return len;
    endfunction

    // bit slot within a write data bit (three phases per bit), small table
    function automatic logic [1:0] slot3(input logic [4:0] p);
        logic [1:0] s;
        unique case (p)
            5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24, 5'd27, 5'd30:
                s = 2'd0;
            5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22, 5'd25, 5'd28, 5'd31:
                s = 2'd1;
            default:
                s = 2'd2;
        endcase
        return s;
    endfunction

endpackage

// ===== src/i2c_master_byte_sequencer_unit.sv =====
// I2C master bit-phase sequencer.
// Input channel (s_*): one transaction per item. A command (start, stop,
// write byte, read byte) loads a sequence and runs no phase; a tick item
// runs the next bus phase (one half-bit delay) of the loaded sequence.
// Sequences are start 3, stop 3, write 27 and read 20 phases long.
// A command while a sequence is loaded is ignored and flagged rejected.
// Output channel (m_*): one result per item with the SCL/SDA/enable levels
// now driven, busy, done, the read byte and write ACK on the done tick.
// The result is registered: it is valid in the cycle after the item is accepted.
// Throughput: one item per cycle while the receiver takes each result; the whole phase step is a single pass of
// logic from the sequencer state into the result register.
// Receiver stall: the result register holds; s_ready stays high while the
// result register is empty or being emptied in the same cycle, so a stall
// of the receiver blocks the input after one item.
// Reset (aresetn low, synchronous): no result pending, sequencer idle,
// SCL, SDA and enable all high.
module i2c_master_byte_sequencer_unit
    import i2cms_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_opcode,
    input  logic [7:0] s_data_byte,
    input  logic       s_send_ack,
    input  logic       s_sda_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_level,
    output logic       m_sda_level,
    output logic       m_sda_drive_enable,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic [7:0] m_read_byte,
    output logic       m_ack_received,
    output logic       m_rejected
);

    typedef enum logic [2:0] {
        KIND_IDLE  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_READ  = 3'd4
    } kind_t;

    kind_t      kind_reg, kind_next;
    logic [2:0] pin_reg, pin_next;
    logic [4:0] phase_reg, phase_next;
    logic [7:0] shift_reg, shift_next;
    logic       ackw_reg, ackw_next;
    logic       ackf_reg, ackf_next;

    logic       m_valid_reg;
    logic       scl_reg, sda_reg, oe_reg, busy_reg, done_reg, ackr_reg, rej_reg;
    logic [7:0] rbyte_reg;

    logic       scl_v, sda_v, oe_v;
    logic       done_v, rej_v, ackr_v;
    logic [7:0] rbyte_v;
    logic       busy, is_cmd, accept;
    logic [5:0] p_inc;
    logic [1:0] slot;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign busy    = kind_reg != KIND_IDLE;
    assign is_cmd  = s_opcode == OP_START || s_opcode == OP_STOP ||
                     s_opcode == OP_WRITE || s_opcode == OP_READ;
    assign p_inc   = {1'b0, phase_reg} + 6'd1;
    assign slot    = slot3(phase_reg);

    always_comb begin
        kind_next  = kind_reg;
        pin_next   = pin_reg;
        phase_next = phase_reg;
        shift_next = shift_reg;
        ackw_next  = ackw_reg;
        ackf_next  = ackf_reg;
        scl_v      = pin_reg[0];
        sda_v      = pin_reg[1];
        oe_v       = pin_reg[2];
        done_v     = 1'b0;
        rej_v      = 1'b0;
        ackr_v     = 1'b0;
        rbyte_v    = 8'd0;

        if (is_cmd) begin
            if (busy) begin
                rej_v = 1'b1;
            end else begin
                kind_next  = kind_t'(s_opcode);
                phase_next = 5'd0;
                if (s_opcode == OP_WRITE) begin
                    shift_next = s_data_byte;
                    ackf_next  = 1'b0;
                end
                if (s_opcode == OP_READ) begin
                    shift_next = 8'd0;
                    ackw_next  = s_send_ack;
                end
            end
        end else if (s_opcode == OP_TICK && busy) begin
            unique case (kind_reg)
                KIND_START: begin
                    oe_v = 1'b1;
                    if (phase_reg == 5'd0) begin
                        sda_v = 1'b1;
                        scl_v = 1'b1;
                    end else if (phase_reg == 5'd1) begin
                        sda_v = 1'b0;
                    end else begin
                        scl_v = 1'b0;
                    end
                end
                KIND_STOP: begin
                    oe_v = 1'b1;
                    if (phase_reg == 5'd0) begin
                        sda_v = 1'b0;
                        scl_v = 1'b0;
                    end else if (phase_reg == 5'd1) begin
                        scl_v = 1'b1;
                    end else begin
                        sda_v = 1'b1;
                    end
                end
                KIND_WRITE: begin
                    if (phase_reg < 5'd24) begin
                        if (slot == 2'd0) begin
                            sda_v = |(shift_reg & MSB_MASK);
                            oe_v  = 1'b1;
                        end else if (slot == 2'd1) begin
                            scl_v = 1'b1;
                        end else begin
                            scl_v      = 1'b0;
                            shift_next = {shift_reg[6:0], 1'b0};
                        end
                    end else if (phase_reg == 5'd24) begin
                        oe_v  = 1'b0;
                        sda_v = 1'b1;
                    end else if (phase_reg == 5'd25) begin
                        scl_v     = 1'b1;
                        ackf_next = !s_sda_in;
                    end else begin
                        scl_v = 1'b0;
                    end
                end
                KIND_READ: begin
                    if (phase_reg == 5'd0) begin
                        oe_v  = 1'b0;
                        sda_v = 1'b1;
                    end else if (phase_reg <= 5'd16) begin
                        // SCL high on odd phases, sample the bit there
                        if (phase_reg[0]) begin
                            scl_v      = 1'b1;
                            shift_next = {shift_reg[6:0], s_sda_in};
                        end else begin
                            scl_v = 1'b0;
                        end
                    end else if (phase_reg == 5'd17) begin
                        oe_v  = 1'b1;
                        sda_v = !ackw_reg;
                    end else if (phase_reg == 5'd18) begin
                        scl_v = 1'b1;
                    end else begin
                        scl_v = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            pin_next   = {oe_v, sda_v, scl_v};
            phase_next = p_inc[4:0];
            if (p_inc >= {1'b0, seq_length(kind_reg)}) begin
                done_v     = 1'b1;
                phase_next = 5'd0;
                kind_next  = KIND_IDLE;
                if (kind_reg == KIND_READ) begin
                    rbyte_v = shift_next;
                end
                if (kind_reg == KIND_WRITE) begin
                    ackr_v = ackf_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg    <= KIND_IDLE;
            pin_reg     <= 3'b111;
            phase_reg   <= 5'd0;
            shift_reg   <= 8'd0;
            ackw_reg    <= 1'b0;
            ackf_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                kind_reg  <= kind_next;
                pin_reg   <= pin_next;
                phase_reg <= phase_next;
                shift_reg <= shift_next;
                ackw_reg  <= ackw_next;
                ackf_reg  <= ackf_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            scl_reg   <= scl_v;
            sda_reg   <= sda_v;
            oe_reg    <= oe_v;
            busy_reg  <= kind_next != KIND_IDLE;
            done_reg  <= done_v;
            rbyte_reg <= rbyte_v;
            ackr_reg  <= ackr_v;
            rej_reg   <= rej_v;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_scl_level        = scl_reg;
    assign m_sda_level        = sda_reg;
    assign m_sda_drive_enable = oe_reg;
    assign m_busy_res         = busy_reg;
    assign m_done_res         = done_reg;
    assign m_read_byte        = rbyte_reg;
    assign m_ack_received     = ackr_reg;
    assign m_rejected         = rej_reg;

endmodule

// ===== src/i2cms_checker.sv =====
module i2cms_checker
    import i2cms_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [2:0] s_opcode,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_sda_level,
    input logic       m_sda_drive_enable,
    input logic       m_busy_res,
    input logic       m_done_res,
    input logic [7:0] m_read_byte,
    input logic       m_ack_received,
    input logic       m_rejected
);

    // finishing a sequence always leaves the sequencer idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done with busy still set");

    // a rejected command leaves the running sequence in place
    a_rej_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> m_busy_res && !m_done_res)
        else $error("rejected while not busy");

    a_rbyte_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_done_res |-> m_read_byte == 8'd0 && !m_ack_received)
        else $error("read byte or ack outside done transaction");

    // a released SDA always has the idle-high level
    a_release_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_sda_drive_enable |-> m_sda_level)
        else $error("sda low while released");

    // a tick is never rejected, whether the block is idle or busy
    a_tick_no_rej: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_opcode == OP_TICK |=> !m_rejected)
        else $error("tick flagged rejected");

endmodule

bind i2c_master_byte_sequencer_unit i2cms_checker u_i2cms_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .s_opcode           (s_opcode),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_sda_level        (m_sda_level),
    .m_sda_drive_enable (m_sda_drive_enable),
    .m_busy_res         (m_busy_res),
    .m_done_res         (m_done_res),
    .m_read_byte        (m_read_byte),
    .m_ack_received     (m_ack_received),
    .m_rejected         (m_rejected)
);
